// File: sv/ueol_pkg.sv
`default_nettype none
package ueol_pkg;

  localparam int MAX_LINES_DEF = 64;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;

  localparam logic [2:0] ST_ANSWERED  = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_INSERTED  = 3'd2;
  localparam logic [2:0] ST_DOMINATED = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  // which three lines feed the redundancy test
  typedef enum logic [1:0] {
    TRI_LO_NEW_HI = 2'd0,
    TRI_LO2_LO_NEW = 2'd1,
    TRI_NEW_HI_HI2 = 2'd2
  } tri_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] slope_or_x;
    logic signed [31:0] intercept;
  } in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [2:0]         status;
  } out_t;

  typedef struct packed {
    logic load_in;
    tri_t tri_sel;
    logic diff_en;
    logic p1_en;
    logic p2_en;
    logic qmul_en;
    logic qacc_en;
    logic qacc_first;
    logic wr_en;
    logic wr_new;
    logic out_load;
    logic out_zero;
  } cmd_t;

  typedef struct packed {
    logic lt;
    logic eq;
    logic bge;
    logic redund;
  } sts_t;

endpackage
`default_nettype wire

// File: sv/upper_envelope_of_lines_top.sv
`default_nettype none
// A query evaluates every stored line in turn; clear and an empty query answer directly.
// Insert scans for the slope position, tests neighbors for redundancy, then moves
// the following entries in the line table and writes the new line.
// One transaction is in work at a time; a finished result waits in the output register.
// Reset (synchronous, rst_n low) empties the table; no clearing pass is needed.
module upper_envelope_of_lines_top #(
  parameter int MAX_LINES = ueol_pkg::MAX_LINES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ueol_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ueol_pkg::out_t     out_data
);

  localparam int AW = $clog2(MAX_LINES);

  ueol_pkg::cmd_t     cmd;
  ueol_pkg::sts_t     sts;
  logic [AW-1:0]      addr_a, addr_b, wr_addr;
  logic [2:0]         status;
  logic signed [63:0] value;

  ueol_ctrl #(.MAX_LINES(MAX_LINES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_data.op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_status(status),
    .cmd       (cmd),
    .sts       (sts),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .wr_addr   (wr_addr)
  );

  ueol_dp #(.MAX_LINES(MAX_LINES)) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .addr_a   (addr_a),
    .addr_b   (addr_b),
    .wr_addr  (wr_addr),
    .in_data  (in_data),
    .sts      (sts),
    .out_value(value)
  );

  assign out_data.value  = value;
  assign out_data.status = status;

endmodule
`default_nettype wire

// File: sv/ueol_dp.sv
`default_nettype none
module ueol_dp #(
  parameter int MAX_LINES = ueol_pkg::MAX_LINES_DEF,
  localparam int AW = $clog2(MAX_LINES)
) (
  input  wire logic           clk,
  input  wire ueol_pkg::cmd_t cmd,
  input  wire logic [AW-1:0]  addr_a,
  input  wire logic [AW-1:0]  addr_b,
  input  wire logic [AW-1:0]  wr_addr,
  input  wire ueol_pkg::in_t  in_data,
  output ueol_pkg::sts_t      sts,
  output logic signed [63:0]  out_value
);

  logic [63:0] mem [MAX_LINES];
  logic [63:0] rda_r, rdb_r;
  logic signed [31:0] s_r, b_r;
  logic signed [32:0] d1_r, e1_r, d2_r, e2_r;
  logic signed [65:0] p1_r, p2_r;
  logic signed [31:0] qb_r;
  logic signed [63:0] best_r, value_r;

  logic signed [31:0] rda_s, rda_b, rdb_s, rdb_b;
  logic signed [31:0] m1, c1, m2, c2, m3, c3;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [63:0] cand;

  assign rda_s = rda_r[63:32];
  assign rda_b = rda_r[31:0];
  assign rdb_s = rdb_r[63:32];
  assign rdb_b = rdb_r[31:0];

  always_comb begin
    m1 = rda_s; c1 = rda_b;
    m2 = s_r;   c2 = b_r;
    m3 = rdb_s; c3 = rdb_b;
    case (cmd.tri_sel)
      ueol_pkg::TRI_LO_NEW_HI: begin
        m1 = rda_s; c1 = rda_b; m2 = s_r;   c2 = b_r;   m3 = rdb_s; c3 = rdb_b;
      end
      ueol_pkg::TRI_LO2_LO_NEW: begin
        m1 = rda_s; c1 = rda_b; m2 = rdb_s; c2 = rdb_b; m3 = s_r;   c3 = b_r;
      end
      ueol_pkg::TRI_NEW_HI_HI2: begin
        m1 = s_r;   c1 = b_r;   m2 = rda_s; c2 = rda_b; m3 = rdb_s; c3 = rdb_b;
      end
      default: begin
        m1 = rda_s; c1 = rda_b; m2 = s_r;   c2 = b_r;   m3 = rdb_s; c3 = rdb_b;
      end
    endcase
  end

  // one shared multiplier: line value for queries, cross products for inserts
  always_comb begin
    if (cmd.qmul_en) begin
      mul_a = 33'(rda_s);
      mul_b = 33'(s_r);
    end else if (cmd.p2_en) begin
      mul_a = d2_r;
      mul_b = e2_r;
    end else begin
      mul_a = d1_r;
      mul_b = e1_r;
    end
  end

  assign mul_p = 66'(mul_a) * 66'(mul_b);
  assign cand  = p1_r[63:0] + 64'(qb_r);

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= cmd.wr_new ? {s_r, b_r} : rda_r;
    end
    rda_r <= mem[addr_a];
    rdb_r <= mem[addr_b];
    if (cmd.load_in) begin
      s_r <= in_data.slope_or_x;
      b_r <= in_data.intercept;
    end
    if (cmd.diff_en) begin
      d1_r <= 33'(c1) - 33'(c2);
      e1_r <= 33'(m3) - 33'(m2);
      d2_r <= 33'(c2) - 33'(c3);
      e2_r <= 33'(m2) - 33'(m1);
    end
    if (cmd.p1_en || cmd.qmul_en) begin
      p1_r <= mul_p;
    end
    if (cmd.qmul_en) begin
      qb_r <= rda_b;
    end
    if (cmd.p2_en) begin
      p2_r <= mul_p;
    end
    if (cmd.qacc_en && (cmd.qacc_first || cand > best_r)) begin
      best_r <= cand;
    end
    if (cmd.out_load) begin
      value_r <= cmd.out_zero ? 64'sd0 : best_r;
    end
  end

  assign sts.lt     = rda_s < s_r;
  assign sts.eq     = rda_s == s_r;
  assign sts.bge    = rda_b >= b_r;
  assign sts.redund = p1_r >= p2_r;
  assign out_value  = value_r;

endmodule
`default_nettype wire

// File: sv/ueol_ctrl.sv
`default_nettype none
module ueol_ctrl #(
  parameter int MAX_LINES = ueol_pkg::MAX_LINES_DEF,
  localparam int AW = $clog2(MAX_LINES),
  localparam int CW = $clog2(MAX_LINES + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [1:0]     in_op,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [2:0]          out_status,
  output ueol_pkg::cmd_t      cmd,
  input  wire ueol_pkg::sts_t sts,
  output logic [AW-1:0]       addr_a,
  output logic [AW-1:0]       addr_b,
  output logic [AW-1:0]       wr_addr
);

  typedef enum logic [4:0] {
    IDLE, F_RD, F_WT, F_CHK, LO_A, C_WT, C_DIF, C_M1, C_M2, C_CMP,
    LO_CHK, HI_CHK, SIZE, SH_RD, SH_WT, SH_WR, NEW_WR, Q_WT, Q_MUL, Q_ACC, DONE
  } state_t;

  localparam logic [CW:0] MAX_W = (CW + 1)'(MAX_LINES);

  state_t         state_r;
  logic [CW-1:0]  n_r, i_r, lo1_r, hi_r, src_r, dst_r, rem_r;
  logic [CW:0]    newn_r;
  logic           up_r, first_r, out_valid_r;
  ueol_pkg::tri_t kind_r;
  logic [2:0]     status_r, out_status_r;
  logic [AW-1:0]  addr_a_r, addr_b_r;

  logic           accept;
  logic [CW:0]    newn;

  assign in_stall = state_r != IDLE;
  assign accept   = in_valid && !in_stall;
  assign newn     = {1'b0, lo1_r} + (CW + 1)'(1) + {1'b0, n_r} - {1'b0, hi_r};

  always_comb begin
    cmd            = '0;
    cmd.load_in    = accept;
    cmd.tri_sel    = kind_r;
    cmd.diff_en    = state_r == C_DIF;
    cmd.p1_en      = state_r == C_M1;
    cmd.p2_en      = state_r == C_M2;
    cmd.qmul_en    = state_r == Q_MUL;
    cmd.qacc_en    = state_r == Q_ACC;
    cmd.qacc_first = first_r;
    cmd.wr_en      = (state_r == SH_WR) || (state_r == NEW_WR);
    cmd.wr_new     = state_r == NEW_WR;
    cmd.out_load   = (state_r == DONE) && !(out_valid_r && out_stall);
    cmd.out_zero   = status_r != ueol_pkg::ST_ANSWERED;
  end

  assign wr_addr    = (state_r == NEW_WR) ? lo1_r[AW-1:0] : dst_r[AW-1:0];
  assign addr_a     = addr_a_r;
  assign addr_b     = addr_b_r;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        IDLE: begin
          if (in_valid) begin
            if (in_op[1]) begin
              n_r      <= '0;
              status_r <= ueol_pkg::ST_CLEARED;
              state_r  <= DONE;
            end else if (in_op == ueol_pkg::OP_INSERT) begin
              i_r     <= '0;
              state_r <= F_RD;
            end else if (n_r == '0) begin
              status_r <= ueol_pkg::ST_EMPTY;
              state_r  <= DONE;
            end else begin
              i_r      <= '0;
              addr_a_r <= '0;
              first_r  <= 1'b1;
              state_r  <= Q_WT;
            end
          end
        end
        // find the first entry whose slope is not below the new one
        F_RD: begin
          if (i_r == n_r) begin
            lo1_r   <= i_r;
            hi_r    <= i_r;
            state_r <= LO_A;
          end else begin
            addr_a_r <= i_r[AW-1:0];
            state_r  <= F_WT;
          end
        end
        F_WT: state_r <= F_CHK;
        F_CHK: begin
          if (sts.lt) begin
            i_r     <= i_r + CW'(1);
            state_r <= F_RD;
          end else if (sts.eq) begin
            if (sts.bge) begin
              status_r <= ueol_pkg::ST_DOMINATED;
              state_r  <= DONE;
            end else begin
              lo1_r   <= i_r;
              hi_r    <= i_r + CW'(1);
              state_r <= LO_A;
            end
          end else begin
            lo1_r   <= i_r;
            hi_r    <= i_r;
            state_r <= LO_A;
          end
        end
        LO_A: begin
          if (lo1_r != '0 && hi_r < n_r) begin
            addr_a_r <= AW'(lo1_r - CW'(1));
            addr_b_r <= hi_r[AW-1:0];
            kind_r   <= ueol_pkg::TRI_LO_NEW_HI;
            state_r  <= C_WT;
          end else begin
            state_r <= LO_CHK;
          end
        end
        C_WT:  state_r <= C_DIF;
        C_DIF: state_r <= C_M1;
        C_M1:  state_r <= C_M2;
        C_M2:  state_r <= C_CMP;
        C_CMP: begin
          case (kind_r)
            ueol_pkg::TRI_LO_NEW_HI: begin
              if (sts.redund) begin
                status_r <= ueol_pkg::ST_DOMINATED;
                state_r  <= DONE;
              end else begin
                state_r <= LO_CHK;
              end
            end
            ueol_pkg::TRI_LO2_LO_NEW: begin
              if (sts.redund) begin
                lo1_r   <= lo1_r - CW'(1);
                state_r <= LO_CHK;
              end else begin
                state_r <= HI_CHK;
              end
            end
            default: begin
              if (sts.redund) begin
                hi_r    <= hi_r + CW'(1);
                state_r <= HI_CHK;
              end else begin
                state_r <= SIZE;
              end
            end
          endcase
        end
        LO_CHK: begin
          if (lo1_r >= CW'(2)) begin
            addr_a_r <= AW'(lo1_r - CW'(2));
            addr_b_r <= AW'(lo1_r - CW'(1));
            kind_r   <= ueol_pkg::TRI_LO2_LO_NEW;
            state_r  <= C_WT;
          end else begin
            state_r <= HI_CHK;
          end
        end
        HI_CHK: begin
          if ({1'b0, hi_r} + (CW + 1)'(1) < {1'b0, n_r}) begin
            addr_a_r <= hi_r[AW-1:0];
            addr_b_r <= AW'(hi_r + CW'(1));
            kind_r   <= ueol_pkg::TRI_NEW_HI_HI2;
            state_r  <= C_WT;
          end else begin
            state_r <= SIZE;
          end
        end
        SIZE: begin
          if (newn > MAX_W) begin
            status_r <= ueol_pkg::ST_FULL;
            state_r  <= DONE;
          end else begin
            newn_r <= newn;
            rem_r  <= n_r - hi_r;
            if (lo1_r + CW'(1) < hi_r) begin
              up_r  <= 1'b1;
              src_r <= hi_r;
              dst_r <= lo1_r + CW'(1);
            end else begin
              up_r  <= 1'b0;
              src_r <= n_r - CW'(1);
              dst_r <= n_r;
            end
            if (n_r == hi_r || lo1_r + CW'(1) == hi_r) begin
              state_r <= NEW_WR;
            end else begin
              state_r <= SH_RD;
            end
          end
        end
        SH_RD: begin
          addr_a_r <= src_r[AW-1:0];
          state_r  <= SH_WT;
        end
        SH_WT: state_r <= SH_WR;
        SH_WR: begin
          rem_r <= rem_r - CW'(1);
          if (up_r) begin
            src_r <= src_r + CW'(1);
            dst_r <= dst_r + CW'(1);
          end else begin
            src_r <= src_r - CW'(1);
            dst_r <= dst_r - CW'(1);
          end
          state_r <= (rem_r == CW'(1)) ? NEW_WR : SH_RD;
        end
        NEW_WR: begin
          n_r      <= newn_r[CW-1:0];
          status_r <= ueol_pkg::ST_INSERTED;
          state_r  <= DONE;
        end
        Q_WT:  state_r <= Q_MUL;
        Q_MUL: state_r <= Q_ACC;
        Q_ACC: begin
          first_r <= 1'b0;
          if (i_r + CW'(1) == n_r) begin
            status_r <= ueol_pkg::ST_ANSWERED;
            state_r  <= DONE;
          end else begin
            i_r      <= i_r + CW'(1);
            addr_a_r <= AW'(i_r + CW'(1));
            state_r  <= Q_WT;
          end
        end
        DONE: begin
          if (!(out_valid_r && out_stall)) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            state_r      <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  localparam int TABLE_DEPTH = ueol_pkg::MAX_LINES_DEF;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ueol_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ueol_pkg::out_t out_data;

  upper_envelope_of_lines_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // envelope model
  longint env_slope[TABLE_DEPTH];
  longint env_icpt[TABLE_DEPTH];
  int env_count = 0;

  ueol_pkg::out_t pending_results[$];
  int error_count = 0;
  int result_count = 0;
  int query_count = 0;
  int insert_count = 0;
  int full_count = 0;
  bit idle_enable = 1'b1;

  // middle line redundant between outer ones; products of 33-bit differences need
  // up to 66 bits signed, so use wider arithmetic
  function automatic bit middle_redundant(longint m1, longint b1, longint m2,
                                          longint b2, longint m3, longint b3);
    logic signed [67:0] lhs;
    logic signed [67:0] rhs;
    lhs = 68'(b1 - b2) * 68'(m3 - m2);
    rhs = 68'(b2 - b3) * 68'(m2 - m1);
    return lhs >= rhs;
  endfunction

  function automatic logic [2:0] envelope_insert(longint s, longint b);
    int n;
    int pos;
    int lo;
    int hi;
    int tail;
    int newn;
    longint ts[TABLE_DEPTH];
    longint tb[TABLE_DEPTH];
    n = env_count;
    pos = 0;
    while (pos < n && env_slope[pos] < s) pos++;
    hi = pos;
    if (pos < n && env_slope[pos] == s) begin
      if (env_icpt[pos] >= b) return ueol_pkg::ST_DOMINATED;
      hi = pos + 1;
    end
    lo = pos - 1;
    if (lo >= 0 && hi < n && middle_redundant(env_slope[lo], env_icpt[lo], s, b,
                                               env_slope[hi], env_icpt[hi]))
      return ueol_pkg::ST_DOMINATED;
    while (lo >= 1 && middle_redundant(env_slope[lo-1], env_icpt[lo-1],
                                       env_slope[lo], env_icpt[lo], s, b))
      lo--;
    while (hi + 1 < n && middle_redundant(s, b, env_slope[hi], env_icpt[hi],
                                          env_slope[hi+1], env_icpt[hi+1]))
      hi++;
    tail = n - hi;
    newn = lo + 2 + tail;
    if (newn > TABLE_DEPTH) return ueol_pkg::ST_FULL;
    ts = env_slope;
    tb = env_icpt;
    for (int k = 0; k < tail; k++) begin
      env_slope[lo + 2 + k] = ts[hi + k];
      env_icpt[lo + 2 + k] = tb[hi + k];
    end
    env_slope[lo + 1] = s;
    env_icpt[lo + 1] = b;
    env_count = newn;
    return ueol_pkg::ST_INSERTED;
  endfunction

  function automatic ueol_pkg::out_t envelope_step(ueol_pkg::in_t item);
    ueol_pkg::out_t r;
    longint x;
    longint best;
    longint v;
    r = '0;
    x = item.slope_or_x;
    if (item.op[1]) begin
      env_count = 0;
      r.status = ueol_pkg::ST_CLEARED;
    end else if (item.op == ueol_pkg::OP_INSERT) begin
      r.status = envelope_insert(item.slope_or_x, item.intercept);
    end else if (env_count == 0) begin
      r.status = ueol_pkg::ST_EMPTY;
    end else begin
      best = env_slope[0] * x + env_icpt[0];
      for (int i = 1; i < env_count; i++) begin
        v = env_slope[i] * x + env_icpt[i];
        if (v > best) best = v;
      end
      r.value = best;
      r.status = ueol_pkg::ST_ANSWERED;
    end
    return r;
  endfunction

  task automatic send_item(logic [1:0] op, logic signed [31:0] a, logic signed [31:0] b);
    ueol_pkg::in_t item;
    item.op = op;
    item.slope_or_x = a;
    item.intercept = b;
    while (idle_enable && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(envelope_step(item));
    if (op == ueol_pkg::OP_INSERT) insert_count++;
    if (op == ueol_pkg::OP_QUERY) query_count++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(40)) - 20);
      3: return 32'(int'($urandom_range(2000)) - 1000);
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin
    ueol_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value %0d status %0d", $time,
                 out_data.value, out_data.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.value !== want.value) begin
          $display("%0t: value expected %0d actual %0d", $time, want.value,
                   out_data.value);
          error_count++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data.status);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk)
    out_stall <= idle_enable && ($urandom_range(99) < 30);

  task automatic test_directed();
    send_item(ueol_pkg::OP_QUERY, 0, 0);
    send_item(ueol_pkg::OP_INSERT, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_item(ueol_pkg::OP_INSERT, 32'sh8000_0000, 32'sh8000_0000);
    send_item(ueol_pkg::OP_QUERY, 32'sh8000_0000, 0);
    send_item(ueol_pkg::OP_QUERY, 32'sh7fff_ffff, 0);
    send_item(OP_CLEAR, 0, 0);
    send_item(ueol_pkg::OP_INSERT, 1, 0);
    send_item(ueol_pkg::OP_INSERT, 1, 0);      // equal slope, equal intercept
    send_item(ueol_pkg::OP_INSERT, 1, -5);     // equal slope, smaller
    send_item(ueol_pkg::OP_INSERT, 1, 3);      // equal slope, larger
    send_item(ueol_pkg::OP_INSERT, -1, 3);
    send_item(ueol_pkg::OP_INSERT, 0, 3);      // touches at one point
    send_item(ueol_pkg::OP_INSERT, 0, 4);      // removes nothing, splices in
    send_item(ueol_pkg::OP_INSERT, 0, 100);    // replaces the equal-slope line
    send_item(ueol_pkg::OP_QUERY, 0, 0);
    send_item(ueol_pkg::OP_QUERY, 97, 0);      // on a breakpoint
    send_item(ueol_pkg::OP_QUERY, -97, 32'shffff_ffff);
    send_item(OP_SPARE, 5, 5);
    send_item(ueol_pkg::OP_QUERY, 1, 1);
  endtask

  task automatic test_full_table();
    send_item(OP_CLEAR, 0, 0);
    // parabola points stay on the envelope: fill past capacity
    for (int k = 0; k < TABLE_DEPTH + 4; k++)
      send_item(ueol_pkg::OP_INSERT, k - 34, -(k - 34) * (k - 34));
    for (int k = 0; k < 8; k++)
      send_item(ueol_pkg::OP_QUERY, int'($urandom_range(80)) - 40, 0);
  endtask

  task automatic test_random();
    int op_pick;
    for (int n = 0; n < 650; n++) begin
      idle_enable = !(n >= 250 && n < 350);
      op_pick = $urandom_range(99);
      if (op_pick < 3)
        send_item($urandom_range(1) ? OP_CLEAR : OP_SPARE, $urandom(), $urandom());
      else if (op_pick < 55)
        send_item(ueol_pkg::OP_INSERT, rand_word(), rand_word());
      else
        send_item(ueol_pkg::OP_QUERY, rand_word(), $urandom());
      if (n == 400) wait_drained();  // hold input until all results return
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_table();
    test_random();
    wait_drained();
    repeat (300) @(posedge clk);
    $display("covered %0d inserts and %0d queries, %0d results checked",
             insert_count, query_count, result_count);
    if (error_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout waiting for results");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
